>>> sv/bf3_pkg.sv
// shared types and constants of the 3x3 rgb box filter
// used by bf3_front, bf3_queue, bf3_back and box_filter_3x3_rgb_core
package bf3_pkg;

  // frame geometry
  localparam int unsigned MAX_WIDTH = 1024;
  localparam int unsigned ADDR_W    = $clog2(MAX_WIDTH);
  localparam int unsigned WIDTH_W   = 11;
  localparam int unsigned HEIGHT_W  = 13;
  localparam int unsigned ROW_W     = HEIGHT_W;
  localparam int unsigned CFG_W     = HEIGHT_W;

  // pixel layout: three 8-bit channels, red in the lowest bits
  localparam int unsigned CH_W   = 8;
  localparam int unsigned NUM_CH = 3;
  localparam int unsigned PIX_W  = CH_W * NUM_CH;
  // sum of one window column (three samples)
  localparam int unsigned COL_W  = CH_W + 2;

  localparam int unsigned QUEUE_DEPTH = 4;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } bf3_reg_e;

  // input item kinds
  typedef enum logic [0:0] {
    FUNC_PIXEL = 1'b0,
    FUNC_FLUSH = 1'b1
  } bf3_func_e;

  // one classified item, passed from front to back
  typedef struct packed {
    logic [ADDR_W-1:0] addr;   // column in the line stores
    logic [PIX_W-1:0]  pix;    // incoming pixel
    logic              upd;    // shift window and touch line stores
    logic              drain;  // flushing: no store write, bottom row = middle
    logic              row1;   // second row: top row = middle
    logic              rs;     // row start: emit last pixel of previous row
    logic              eof;    // that row-start result closes the frame
    logic              nr;     // emit the result of the column left of center
    logic              col1;   // column one: left edge clamp
    logic              w1;     // frame one pixel wide
  } bf3_op_t;

  // column sums of all three channels
  typedef logic [NUM_CH-1:0][COL_W-1:0] bf3_colsum_t;

endpackage

>>> sv/bf3_front.sv
// front end: configuration registers, frame position counters and item classification
// depends on bf3_pkg
module bf3_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [0:0]                 cfg_addr_i,
  input  logic [bf3_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       in_func_i,
  input  logic [bf3_pkg::PIX_W-1:0]  in_pix_i,
  input  logic                       q_full_i,
  output logic                       push_o,
  output bf3_pkg::bf3_op_t           op_o
);

  logic [bf3_pkg::WIDTH_W-1:0]  width_q;
  logic [bf3_pkg::HEIGHT_W-1:0] height_q;
  logic [bf3_pkg::ADDR_W-1:0]   col_q, col_d;
  logic [bf3_pkg::ROW_W-1:0]    row_q, row_d;

  logic [bf3_pkg::WIDTH_W-1:0]  w_eff;
  logic [bf3_pkg::HEIGHT_W-1:0] h_eff;
  logic [bf3_pkg::ADDR_W-1:0]   col;
  logic [bf3_pkg::WIDTH_W-1:0]  col_next;
  logic                         draining;
  logic                         accept;
  logic                         ignore;
  logic                         row_start;
  logic                         eof;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bf3_pkg::WIDTH_W'(1024);
      height_q <= bf3_pkg::HEIGHT_W'(1024);
    end else if (cfg_we_i) begin
      case (bf3_pkg::bf3_reg_e'(cfg_addr_i))
        bf3_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i[bf3_pkg::WIDTH_W-1:0];
        bf3_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_wdata_i[bf3_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the geometry into the supported range
  always_comb begin
    if (width_q == '0) begin
      w_eff = bf3_pkg::WIDTH_W'(1);
    end else if (width_q > bf3_pkg::WIDTH_W'(bf3_pkg::MAX_WIDTH)) begin
      w_eff = bf3_pkg::WIDTH_W'(bf3_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    h_eff = (height_q == '0) ? bf3_pkg::HEIGHT_W'(1) : height_q;
  end

  // classify the incoming item
  always_comb begin
    col       = ({1'b0, col_q} >= w_eff) ? '0 : col_q;
    draining  = row_q >= h_eff;
    accept    = in_valid_i && in_ready_o;
    ignore    = !draining && (in_func_i == bf3_pkg::FUNC_FLUSH);
    row_start = (col == '0) && (row_q >= bf3_pkg::ROW_W'(2));
    eof       = draining && ({1'b0, row_q} >= ({1'b0, h_eff} + 14'd1));
    col_next  = {1'b0, col} + bf3_pkg::WIDTH_W'(1);

    op_o.addr  = col;
    op_o.pix   = in_pix_i;
    op_o.upd   = !(row_start && eof);
    op_o.drain = draining;
    op_o.row1  = row_q == bf3_pkg::ROW_W'(1);
    op_o.rs    = row_start;
    op_o.eof   = eof;
    op_o.nr    = (col != '0) && (row_q != '0);
    op_o.col1  = col == bf3_pkg::ADDR_W'(1);
    op_o.w1    = w_eff == bf3_pkg::WIDTH_W'(1);

    in_ready_o = !q_full_i;
    push_o     = accept && !ignore;

    // frame position of the next item
    col_d = col_q;
    row_d = row_q;
    if (accept && !ignore) begin
      if (row_start && eof) begin
        col_d = '0;
        row_d = '0;
      end else if (col_next >= w_eff) begin
        col_d = '0;
        row_d = row_q + bf3_pkg::ROW_W'(1);
      end else begin
        col_d = col_next[bf3_pkg::ADDR_W-1:0];
      end
    end else if (accept) begin
      col_d = col;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

>>> sv/bf3_queue.sv
// short fifo of classified items between front and back
// depends on bf3_pkg
module bf3_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  bf3_pkg::bf3_op_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output bf3_pkg::bf3_op_t data_o
);

  localparam int unsigned PTR_W = $clog2(bf3_pkg::QUEUE_DEPTH);

  bf3_pkg::bf3_op_t   entry_q [bf3_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]     count_q, count_d;

  // pointer and fill count
  always_comb begin
    full_o   = count_q == (PTR_W+1)'(bf3_pkg::QUEUE_DEPTH);
    empty_o  = count_q == '0;
    data_o   = entry_q[rd_ptr_q];
    wr_ptr_d = push_i ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + (PTR_W+1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> sv/bf3_back.sv
// back end: line stores, window column sums, 3x3 sum and divide by nine
// depends on bf3_pkg
module bf3_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_empty_i,
  input  bf3_pkg::bf3_op_t           q_data_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [bf3_pkg::PIX_W-1:0]  out_pix_o,
  output logic                       out_eof_o
);

  localparam int unsigned LINE_W = 2 * bf3_pkg::PIX_W;
  localparam int unsigned SUM_W  = bf3_pkg::COL_W + 2;
  // reciprocal of nine in 16 fractional bits, exact for sums up to 9*255
  localparam int unsigned RECIP_W = 13;
  localparam logic [RECIP_W-1:0] RECIP9 = RECIP_W'(7282);
  localparam int unsigned PROD_W = SUM_W + RECIP_W;

  // line stores: upper row in the high half, middle row in the low half
  logic [LINE_W-1:0] line_mem [bf3_pkg::MAX_WIDTH];
  logic [LINE_W-1:0] mem_rd_q;
  logic              byp_q;
  logic [LINE_W-1:0] byp_data_q;

  bf3_pkg::bf3_op_t    s1_q;
  logic                s1_v_q;
  bf3_pkg::bf3_colsum_t col_sum_q [3];
  bf3_pkg::bf3_colsum_t s2_a_q, s2_b_q, s2_c_q;
  logic                s2_v_q;
  logic                s2_eof_q;
  logic                out_v_q;
  logic                out_eof_q;
  logic [bf3_pkg::PIX_W-1:0] out_pix_q;

  logic                 adv;
  logic                 wr_en;
  logic [LINE_W-1:0]    rd_data;
  logic [LINE_W-1:0]    wr_data;
  logic [bf3_pkg::PIX_W-1:0] top, mid, bot;
  bf3_pkg::bf3_colsum_t new_col;
  bf3_pkg::bf3_colsum_t sel_a, sel_c;
  logic                 res_v;
  logic [bf3_pkg::PIX_W-1:0] avg;
  logic [SUM_W-1:0]     sum;
  logic [PROD_W-1:0]    prod;

  // pipeline moves whenever the output register is free or being drained
  assign adv   = !out_v_q || out_ready_i;
  assign pop_o = !q_empty_i && (adv || !s1_v_q);
  assign wr_en = s1_v_q && adv && s1_q.upd && !s1_q.drain;

  // stage one: rows of the new window column
  always_comb begin
    rd_data = byp_q ? byp_data_q : mem_rd_q;
    mid     = rd_data[bf3_pkg::PIX_W-1:0];
    top     = s1_q.row1 ? mid : rd_data[LINE_W-1:bf3_pkg::PIX_W];
    bot     = s1_q.drain ? mid : s1_q.pix;
    wr_data = {mid, s1_q.pix};
    for (int ch = 0; ch < bf3_pkg::NUM_CH; ch++) begin
      new_col[ch] = bf3_pkg::COL_W'(top[ch*bf3_pkg::CH_W +: bf3_pkg::CH_W])
                  + bf3_pkg::COL_W'(mid[ch*bf3_pkg::CH_W +: bf3_pkg::CH_W])
                  + bf3_pkg::COL_W'(bot[ch*bf3_pkg::CH_W +: bf3_pkg::CH_W]);
    end
    // row start uses the window before the shift, others the window after it
    if (s1_q.rs) begin
      sel_a = s1_q.w1 ? col_sum_q[2] : col_sum_q[1];
      sel_c = col_sum_q[2];
    end else begin
      sel_a = s1_q.col1 ? col_sum_q[2] : col_sum_q[1];
      sel_c = new_col;
    end
    res_v = s1_q.rs || (s1_q.upd && s1_q.nr);
  end

  // line store write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[s1_q.addr] <= wr_data;
    end
    if (pop_o) begin
      mem_rd_q <= line_mem[q_data_i.addr];
    end
  end

  // forward a write to the same column that the next item reads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (pop_o) begin
      byp_q <= wr_en && (s1_q.addr == q_data_i.addr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      byp_data_q <= wr_data;
      s1_q       <= q_data_i;
    end
  end

  // valid flags of the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (adv || !s1_v_q) begin
        s1_v_q <= !q_empty_i;
      end
      if (adv) begin
        s2_v_q  <= s1_v_q && res_v;
        out_v_q <= s2_v_q;
      end
    end
  end

  // window column sums, cleared at reset like the window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_sum_q[0] <= '0;
      col_sum_q[1] <= '0;
      col_sum_q[2] <= '0;
    end else if (s1_v_q && adv && s1_q.upd) begin
      col_sum_q[0] <= col_sum_q[1];
      col_sum_q[1] <= col_sum_q[2];
      col_sum_q[2] <= new_col;
    end
  end

  // stage two: the three chosen column sums
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_a_q   <= sel_a;
      s2_b_q   <= col_sum_q[2];
      s2_c_q   <= sel_c;
      s2_eof_q <= s1_q.rs && s1_q.eof;
    end
  end

  // nine-sample sum and divide by nine per channel
  always_comb begin
    avg  = '0;
    sum  = '0;
    prod = '0;
    for (int ch = 0; ch < bf3_pkg::NUM_CH; ch++) begin
      sum  = SUM_W'(s2_a_q[ch]) + SUM_W'(s2_b_q[ch]) + SUM_W'(s2_c_q[ch]);
      prod = PROD_W'(sum) * PROD_W'(RECIP9);
      avg[ch*bf3_pkg::CH_W +: bf3_pkg::CH_W] = prod[16 +: bf3_pkg::CH_W];
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_pix_q <= avg;
      out_eof_q <= s2_eof_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_pix_o   = out_pix_q;
  assign out_eof_o   = out_eof_q;

endmodule

>>> sv/box_filter_3x3_rgb_core.sv
// top level of the 3x3 rgb box filter with clamp-to-edge borders
// depends on bf3_pkg, bf3_front, bf3_queue and bf3_back
//
// usage: pixels enter in raster order on the s_axis channel, one item per
// clock while s_axis_tready is high; tuser = 0 marks a pixel, tuser = 1 a
// flush item. after the last pixel of a frame, image_width + 1 flush items
// push out the remaining results; the frame's last result leaves with
// m_axis_tlast high. flush items sent inside a frame are taken and dropped.
// image_width and image_height are set through the cfg port; the user must
// write them only while no frame is in flight; the block does not enforce
// this. throughput: one item per clock while m_axis_tready is high, set by
// the single-ported read of the line store per item and the registered forward
// of a same-column write. an accepted item passes the queue, line store read,
// column select and divide on its way to m_axis. result of pixel p of a frame
// is caused by item p + width + 1. reset clears the frame counters, window and
// pipeline, and sets width and height to 1024; the line stores are not
// cleared. a stalled receiver holds the output register and the back pipeline;
// the four-entry queue keeps accepting until it is full.
module box_filter_3x3_rgb_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_we_i,
  input  logic [0:0]                 cfg_addr_i,
  input  logic [bf3_pkg::CFG_W-1:0]  cfg_wdata_i,
  // input items
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [23:0]                s_axis_tdata,  // red_in, green_in, blue_in
  input  logic [0:0]                 s_axis_tuser,  // func
  // result items
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [23:0]                m_axis_tdata,  // red_avg, green_avg, blue_avg
  output logic                       m_axis_tlast   // end_of_frame
);

  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;
  bf3_pkg::bf3_op_t op_in;
  bf3_pkg::bf3_op_t op_out;

  // classification and counters
  bf3_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_func_i   (s_axis_tuser[0]),
    .in_pix_i    (s_axis_tdata),
    .q_full_i    (q_full),
    .push_o      (push),
    .op_o        (op_in)
  );

  // decoupling queue
  bf3_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (op_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .data_o  (op_out)
  );

  // line stores and averaging
  bf3_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (op_out),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pix_o   (m_axis_tdata),
    .out_eof_o   (m_axis_tlast)
  );

endmodule
